@@ rtl/core/rmdu_pkg.sv @@
`default_nettype none

package rmdu_pkg;

   localparam int VW    = 32;
   localparam int CNT_W = $clog2(VW);

   localparam logic [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] NEG_MAX = {1'b1, {(VW-1){1'b0}}};

   localparam logic [1:0] OP_NORM = 2'd0;
   localparam logic [1:0] OP_MUL  = 2'd1;
   localparam logic [1:0] OP_DIV  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef struct packed {
      logic          start;
      logic          mul;
      logic [VW-1:0] a;
      logic [VW-1:0] b;
   } arith_cmd_type;

   typedef struct packed {
      logic          done;
      logic [VW-1:0] hi;
      logic [VW-1:0] lo;
   } arith_rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/rational_multiply_divide_unit.sv @@
// channel   handshake         payload
// request   start, busy       req_operation, req_first_num/den, req_second_num/den
// result    rsp_valid strobe  rsp_result_num, rsp_result_den, rsp_status
//
// one item at a time; busy is high from acceptance until the result beat.
// every multiply, divide and euclid step runs on one bit-serial unit.
// a reduction runs k euclid steps, k up to about 46, then divides by the gcd.
// a divide item does up to three reductions and two multiplies, so the euclid
// loop sets the time; a zero denominator ends the item in the check state.
// synchronous reset clears the sequencer; the result beat cannot be stalled.
`default_nettype none

module rational_multiply_divide_unit
   import rmdu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_first_num,
   input  wire logic [31:0] req_first_den,
   input  wire logic [31:0] req_second_num,
   input  wire logic [31:0] req_second_den,
   output logic             rsp_valid,
   output logic [31:0]      rsp_result_num,
   output logic [30:0]      rsp_result_den,
   output logic [1:0]       rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_RED, S_GCD, S_GCDW, S_DIVN, S_DIVD, S_RCHK,
      S_NEXT, S_MULN, S_MULNW, S_MULDW
   } state_type;

   typedef enum logic [1:0] {P_FIRST, P_SECOND, P_PROD} phase_type;

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic          busy_ff, busy_in;
   logic          valid_ff, valid_in;
   logic [31:0]   rnum_ff, rnum_in;
   logic [30:0]   rden_ff, rden_in;
   logic [1:0]    status_ff, status_in;
   logic [1:0]    op_ff, op_in;
   logic [VW-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic          aneg_ff, aneg_in, bneg_ff, bneg_in;
   logic [VW-1:0] xn_ff, xn_in, xd_ff, xd_in;
   logic          xneg_ff, xneg_in;
   logic [VW-1:0] ga_ff, ga_in, gb_ff, gb_in;
   arith_cmd_type cmd_ff, cmd_in;
   arith_rsp_type arsp;

   logic [VW-1:0] f1n, f1d, f2n, f2d;
   logic [VW-1:0] m1n, m1d, m2n, m2d;
   logic [VW-1:0] nlim;
   logic [2*VW-1:0] prod;
   logic          pneg;
   logic          is_md;

   rmdu_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .rsp   (arsp)
   );

   assign f1n  = req_first_num[VW-1:0];
   assign f1d  = req_first_den[VW-1:0];
   assign f2n  = req_second_num[VW-1:0];
   assign f2d  = req_second_den[VW-1:0];
   assign m1n  = f1n[VW-1] ? (~f1n + 1'b1) : f1n;
   assign m1d  = f1d[VW-1] ? (~f1d + 1'b1) : f1d;
   assign m2n  = f2n[VW-1] ? (~f2n + 1'b1) : f2n;
   assign m2d  = f2d[VW-1] ? (~f2d + 1'b1) : f2d;
   assign nlim = xneg_ff ? NEG_MAX : POS_MAX;
   assign prod = {arsp.hi, arsp.lo};
   assign pneg = aneg_ff ^ bneg_ff;
   assign is_md = (op_ff == OP_MUL) || (op_ff == OP_DIV);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      busy_in   = busy_ff;
      valid_in  = 1'b0;
      rnum_in   = rnum_ff;
      rden_in   = rden_ff;
      status_in = status_ff;
      op_in     = op_ff;
      an_in     = an_ff;
      ad_in     = ad_ff;
      aneg_in   = aneg_ff;
      bn_in     = bn_ff;
      bd_in     = bd_ff;
      bneg_in   = bneg_ff;
      xn_in     = xn_ff;
      xd_in     = xd_ff;
      xneg_in   = xneg_ff;
      ga_in     = ga_ff;
      gb_in     = gb_ff;
      cmd_in    = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               busy_in  = 1'b1;
               op_in    = req_operation;
               an_in    = m1n;
               ad_in    = m1d;
               aneg_in  = f1n[VW-1] ^ f1d[VW-1];
               bn_in    = m2n;
               bd_in    = m2d;
               bneg_in  = f2n[VW-1] ^ f2d[VW-1];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (ad_ff == '0 || (is_md && bd_ff == '0)) begin
               status_in = ST_ZERO_DEN;
               state_in  = S_IDLE;
            end else begin
               xn_in    = an_ff;
               xd_in    = ad_ff;
               xneg_in  = aneg_ff;
               phase_in = P_FIRST;
               state_in = S_RED;
            end
         end
         S_RED: begin
            if (xn_ff == '0) begin
               xd_in    = VW'(1);
               xneg_in  = 1'b0;
               state_in = S_NEXT;
            end else begin
               ga_in    = xn_ff;
               gb_in    = xd_ff;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            cmd_in.start = 1'b1;
            if (gb_ff == '0) begin
               cmd_in.a = xn_ff;
               cmd_in.b = ga_ff;
               state_in = S_DIVN;
            end else begin
               cmd_in.a = ga_ff;
               cmd_in.b = gb_ff;
               state_in = S_GCDW;
            end
         end
         S_GCDW: begin
            if (arsp.done) begin
               ga_in    = gb_ff;
               gb_in    = arsp.hi;
               state_in = S_GCD;
            end
         end
         S_DIVN: begin
            if (arsp.done) begin
               xn_in        = arsp.lo;
               cmd_in.start = 1'b1;
               cmd_in.a     = xd_ff;
               cmd_in.b     = ga_ff;
               state_in     = S_DIVD;
            end
         end
         S_DIVD: begin
            if (arsp.done) begin
               xd_in    = arsp.lo;
               state_in = S_RCHK;
            end
         end
         S_RCHK: begin
            if (xd_ff > POS_MAX || xn_ff > nlim) begin
               status_in = ST_OVERFLOW;
               state_in  = S_IDLE;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            case (phase_ff)
               P_FIRST: begin
                  an_in   = xn_ff;
                  ad_in   = xd_ff;
                  aneg_in = xneg_ff;
                  if (!is_md) begin
                     status_in = ST_OK;
                     state_in  = S_IDLE;
                  end else begin
                     xn_in    = bn_ff;
                     xd_in    = bd_ff;
                     xneg_in  = bneg_ff;
                     phase_in = P_SECOND;
                     state_in = S_RED;
                  end
               end
               P_SECOND: begin
                  bneg_in = xneg_ff;
                  if (op_ff == OP_MUL) begin
                     bn_in    = xn_ff;
                     bd_in    = xd_ff;
                     state_in = S_MULN;
                  end else if (xn_ff == '0) begin
                     status_in = ST_DIV_ZERO;
                     state_in  = S_IDLE;
                  end else if (xn_ff > POS_MAX) begin
                     status_in = ST_OVERFLOW;
                     state_in  = S_IDLE;
                  end else begin
                     // reciprocal of a reduced fraction is already reduced
                     bn_in    = xd_ff;
                     bd_in    = xn_ff;
                     state_in = S_MULN;
                  end
               end
               default: begin
                  status_in = ST_OK;
                  state_in  = S_IDLE;
               end
            endcase
         end
         S_MULN: begin
            cmd_in.start = 1'b1;
            cmd_in.mul   = 1'b1;
            cmd_in.a     = an_ff;
            cmd_in.b     = bn_ff;
            state_in     = S_MULNW;
         end
         S_MULNW: begin
            if (arsp.done) begin
               if (prod > {{VW{1'b0}}, (pneg ? NEG_MAX : POS_MAX)}) begin
                  status_in = ST_OVERFLOW;
                  state_in  = S_IDLE;
               end else begin
                  xn_in        = arsp.lo;
                  cmd_in.start = 1'b1;
                  cmd_in.mul   = 1'b1;
                  cmd_in.a     = ad_ff;
                  cmd_in.b     = bd_ff;
                  state_in     = S_MULDW;
               end
            end
         end
         S_MULDW: begin
            if (arsp.done) begin
               if (prod > {{VW{1'b0}}, POS_MAX}) begin
                  status_in = ST_OVERFLOW;
                  state_in  = S_IDLE;
               end else begin
                  xd_in    = arsp.lo;
                  xneg_in  = pneg;
                  phase_in = P_PROD;
                  state_in = S_RED;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // result beat on every return to idle
      if (state_ff != S_IDLE && state_in == S_IDLE) begin
         busy_in  = 1'b0;
         valid_in = 1'b1;
         if (status_in == ST_OK) begin
            rnum_in = 32'(xneg_ff ? (~xn_ff + 1'b1) : xn_ff);
            rden_in = 31'(xd_ff);
         end else begin
            rnum_in = '0;
            rden_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= P_FIRST;
         busy_ff   <= 1'b0;
         valid_ff  <= 1'b0;
         cmd_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         busy_ff   <= busy_in;
         valid_ff  <= valid_in;
         cmd_ff    <= cmd_in;
      end
      rnum_ff   <= rnum_in;
      rden_ff   <= rden_in;
      status_ff <= status_in;
      op_ff     <= op_in;
      an_ff     <= an_in;
      ad_ff     <= ad_in;
      aneg_ff   <= aneg_in;
      bn_ff     <= bn_in;
      bd_ff     <= bd_in;
      bneg_ff   <= bneg_in;
      xn_ff     <= xn_in;
      xd_ff     <= xd_in;
      xneg_ff   <= xneg_in;
      ga_ff     <= ga_in;
      gb_ff     <= gb_in;
   end

   assign busy           = busy_ff;
   assign rsp_valid      = valid_ff;
   assign rsp_result_num = rnum_ff;
   assign rsp_result_den = rden_ff;
   assign rsp_status     = status_ff;

endmodule

`default_nettype wire

@@ rtl/core/rmdu_arith.sv @@
`default_nettype none

module rmdu_arith
   import rmdu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire arith_cmd_type cmd,
   output arith_rsp_type      rsp
);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             mul_ff, mul_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VW:0]      hi_ff, hi_in;
   logic [VW-1:0]    lo_ff, lo_in;
   logic [VW-1:0]    b_ff, b_in;
   logic [VW:0]      sum;
   logic [VW:0]      trial;
   logic             ge;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      mul_in  = mul_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      b_in    = b_ff;
      sum     = hi_ff + (lo_ff[0] ? {1'b0, b_ff} : '0);
      trial   = {hi_ff[VW-1:0], lo_ff[VW-1]};
      ge      = trial >= {1'b0, b_ff};
      if (cmd.start) begin
         run_in = 1'b1;
         mul_in = cmd.mul;
         cnt_in = '0;
         hi_in  = '0;
         lo_in  = cmd.a;
         b_in   = cmd.b;
      end else if (run_ff) begin
         // shift-add for multiply, restoring step for divide
         if (mul_ff) begin
            hi_in = {1'b0, sum[VW:1]};
            lo_in = {sum[0], lo_ff[VW-1:1]};
         end else begin
            hi_in = ge ? (trial - {1'b0, b_ff}) : trial;
            lo_in = {lo_ff[VW-2:0], ge};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VW-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mul_ff <= mul_in;
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      b_ff   <= b_in;
   end

   assign rsp.done = done_ff;
   assign rsp.hi   = hi_ff[VW-1:0];
   assign rsp.lo   = lo_ff;

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import rmdu_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [31:0] req_first_num;
   logic [31:0] req_first_den;
   logic [31:0] req_second_num;
   logic [31:0] req_second_den;
   logic        rsp_valid;
   logic [31:0] rsp_result_num;
   logic [30:0] rsp_result_den;
   logic [1:0]  rsp_status;

   typedef struct {
      logic [31:0] num;
      logic [30:0] den;
      logic [1:0]  status;
   } fraction_result_type;

   typedef struct {
      bit          neg;
      logic [63:0] mag_n;
      logic [63:0] mag_d;
   } signed_fraction_type;

   fraction_result_type pending_results[$];
   int error_count = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int send_idle_pct = 0;
   int op_count[4] = '{0, 0, 0, 0};
   int status_count[4] = '{0, 0, 0, 0};

   rational_multiply_divide_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_first_num  (req_first_num),
      .req_first_den  (req_first_den),
      .req_second_num (req_second_num),
      .req_second_den (req_second_den),
      .rsp_valid      (rsp_valid),
      .rsp_result_num (rsp_result_num),
      .rsp_result_den (rsp_result_den),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(input logic [31:0] raw);
      return raw[31] ? 64'(-raw) & 64'hFFFF_FFFF : {32'd0, raw};
   endfunction

   function automatic logic [63:0] euclid(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic logic [1:0] canonical(input bit sn, input logic [63:0] mn,
                                            input bit sd, input logic [63:0] md,
                                            output signed_fraction_type f);
      logic [63:0] g;
      bit neg;
      f.neg = 1'b0;
      f.mag_n = 0;
      f.mag_d = 1;
      if (mn == 0) return ST_OK;
      g = euclid(mn, md);
      neg = sn != sd;
      if (md / g > {32'd0, POS_MAX}) return ST_OVERFLOW;
      if (mn / g > (neg ? {32'd0, NEG_MAX} : {32'd0, POS_MAX})) return ST_OVERFLOW;
      f.neg = neg;
      f.mag_n = mn / g;
      f.mag_d = md / g;
      return ST_OK;
   endfunction

   function automatic logic [1:0] product(input signed_fraction_type a,
                                          input signed_fraction_type b,
                                          output signed_fraction_type r);
      bit neg;
      logic [63:0] lim;
      neg = a.neg != b.neg;
      lim = neg ? {32'd0, NEG_MAX} : {32'd0, POS_MAX};
      r.neg = 1'b0;
      r.mag_n = 0;
      r.mag_d = 0;
      if (a.mag_n != 0 && b.mag_n != 0 && b.mag_n > lim / a.mag_n) return ST_OVERFLOW;
      if (b.mag_d > {32'd0, POS_MAX} / a.mag_d) return ST_OVERFLOW;
      return canonical(neg, a.mag_n * b.mag_n, 1'b0, a.mag_d * b.mag_d, r);
   endfunction

   function automatic fraction_result_type fraction_result(input logic [1:0] op,
         input logic [31:0] n1, input logic [31:0] d1,
         input logic [31:0] n2, input logic [31:0] d2);
      fraction_result_type res;
      signed_fraction_type a, b, inv, r;
      logic [1:0] st;
      bit two_operand;
      two_operand = (op == OP_MUL) || (op == OP_DIV);
      r.neg = 1'b0;
      r.mag_n = 0;
      r.mag_d = 0;
      if (d1 == 0) st = ST_ZERO_DEN;
      else if (two_operand && d2 == 0) st = ST_ZERO_DEN;
      else begin
         st = canonical(n1[31], magnitude(n1), d1[31], magnitude(d1), a);
         if (st == ST_OK && !two_operand) r = a;
         else if (st == ST_OK) begin
            st = canonical(n2[31], magnitude(n2), d2[31], magnitude(d2), b);
            if (st == ST_OK && op == OP_MUL) st = product(a, b, r);
            else if (st == ST_OK && b.mag_n == 0) st = ST_DIV_ZERO;
            else if (st == ST_OK) begin
               st = canonical(b.neg, b.mag_d, 1'b0, b.mag_n, inv);
               if (st == ST_OK) st = product(a, inv, r);
            end
         end
      end
      if (st != ST_OK) begin
         res.num = '0;
         res.den = '0;
      end else begin
         res.num = r.neg ? 32'(-r.mag_n) : r.mag_n[31:0];
         res.den = r.mag_d[30:0];
      end
      res.status = st;
      return res;
   endfunction

   task automatic send_fraction_op(input logic [1:0] op,
                                   input logic [31:0] n1, input logic [31:0] d1,
                                   input logic [31:0] n2, input logic [31:0] d2);
      do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      start <= 1'b1;
      req_operation <= op;
      req_first_num <= n1;
      req_first_den <= d1;
      req_second_num <= n2;
      req_second_den <= d2;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(fraction_result(op, n1, d1, n2, d2));
      beats_sent++;
      op_count[op]++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   always @(posedge clock) begin
      fraction_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat num %h den %h status %0d", $time,
                     rsp_result_num, rsp_result_den, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            beats_checked++;
            status_count[want.status]++;
            if (rsp_result_num !== want.num || rsp_result_den !== want.den ||
                rsp_status !== want.status) begin
               $display("%0t: expected num %h den %h status %0d, actual num %h den %h status %0d",
                        $time, want.num, want.den, want.status,
                        rsp_result_num, rsp_result_den, rsp_status);
               error_count++;
            end
         end
      end
   end

   function automatic logic [31:0] edge_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'd1;
         4: return 32'd0;
         5: return 32'(int'($urandom_range(40)) - 20);
         6: return 32'(1) << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] mid_value();
      logic [31:0] v;
      v = $urandom_range(65535) >> $urandom_range(15);
      if (v == 0) v = 1;
      v = v * (32'd1 << $urandom_range(3));
      return $urandom_range(1) ? -v : v;
   endfunction

   task automatic test_directed();
      send_fraction_op(OP_NORM, 32'd6, 32'd4, 0, 0);
      send_fraction_op(OP_NORM, 32'd6, -32'd4, 0, 0);
      send_fraction_op(OP_NORM, 32'd0, -32'd7, 0, 0);
      send_fraction_op(OP_NORM, 32'd5, 32'd0, 0, 0);
      send_fraction_op(OP_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
      send_fraction_op(OP_NORM, 32'h8000_0000, 32'd1, 0, 0);
      send_fraction_op(OP_NORM, 32'd3, 32'h8000_0000, 0, 0);
      send_fraction_op(OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0);
      send_fraction_op(OP_NORM, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send_fraction_op(2'd3, 32'd10, -32'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fraction_op(OP_MUL, 32'd2, 32'd3, 32'd9, 32'd4);
      send_fraction_op(OP_MUL, 32'd1, 32'd2, 32'd3, 32'd0);
      send_fraction_op(OP_MUL, 32'd0, 32'd5, 32'd3, 32'd0);
      send_fraction_op(OP_MUL, 32'h0001_0000, 1, 32'h0000_8000, 1);
      send_fraction_op(OP_MUL, -32'h0001_0000, 1, 32'h0000_8000, 1);
      send_fraction_op(OP_MUL, 1, 32'h0001_0000, 1, 32'h0000_8000);
      send_fraction_op(OP_MUL, 32'h8000_0000, 1, 32'hFFFF_FFFF, 1);
      send_fraction_op(OP_DIV, 32'd2, 32'd3, 32'd4, 32'd5);
      send_fraction_op(OP_DIV, 32'd2, 32'd3, 32'd0, 32'd5);
      send_fraction_op(OP_DIV, 32'd2, 32'd0, 32'd0, 32'd0);
      send_fraction_op(OP_DIV, 32'd1, 32'd1, 32'h8000_0000, 32'd1);
      send_fraction_op(OP_DIV, 32'd1, 32'd1, 32'h8000_0000, 32'd3);
      send_fraction_op(OP_DIV, 32'd1, 32'd1, -32'd3, 32'h8000_0000);
      send_fraction_op(OP_DIV, 32'h7FFF_FFFF, 1, 1, 2);
      send_fraction_op(OP_NORM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
   endtask

   task automatic test_random(input int count, input int idle_pct);
      logic [31:0] v[4];
      send_idle_pct = idle_pct;
      repeat (count) begin
         foreach (v[k]) begin
            case ($urandom_range(9))
               0, 1: v[k] = edge_value();
               2, 3: v[k] = $urandom;
               default: v[k] = mid_value();
            endcase
         end
         send_fraction_op(2'($urandom_range(3)), v[0], v[1], v[2], v[3]);
      end
      send_idle_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = '0;
      req_first_num = '0;
      req_first_den = '0;
      req_second_num = '0;
      req_second_den = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(420, 0);
      test_random(420, 69);
      test_random(200, 30);
      test_random(200, 0);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("beats sent %0d checked %0d; normalize %0d multiply %0d divide %0d spare op %0d",
               beats_sent, beats_checked, op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("status seen: ok %0d zero den %0d div zero %0d overflow %0d",
               status_count[0], status_count[1], status_count[2], status_count[3]);
      if (error_count == 0 && pending_results.size() == 0)
         $display("rational_multiply_divide_unit test passed");
      else
         $display("rational_multiply_divide_unit test failed");
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("rational_multiply_divide_unit test failed");
      $finish;
   end

endmodule
